// ===== rtl/hae_pkg.sv =====
// shared types and constants of the histogram auto exposure block
// no dependencies; imported by every other rtl file
`default_nettype none

package hae_pkg;

	localparam int BINS_DEFAULT = 64;
	localparam int FIFO_DEPTH   = 2;
	localparam int REGIONS      = 5;

	localparam int COUNT_W  = 24;
	localparam int VAL_W    = 16;
	localparam int TOTAL_W  = 32;
	localparam int WSUM_W   = 35;
	localparam int SETTLE_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int ADJ_W    = 2;

	// mean sample value band edges, scaled by ten
	localparam int MSV_LO_X10 = 23;
	localparam int MSV_HI_X10 = 27;
	localparam int MSV_SCALE  = 10;

	// register reset values
	localparam logic [VAL_W-1:0]    EXP_LO_RST  = 16'd1;
	localparam logic [VAL_W-1:0]    EXP_HI_RST  = 16'd65535;
	localparam logic [VAL_W-1:0]    GAIN_LO_RST = 16'd100;
	localparam logic [VAL_W-1:0]    GAIN_HI_RST = 16'd65535;
	localparam logic [VAL_W-1:0]    STEP_RST    = 16'd30;
	localparam logic [SETTLE_W-1:0] SETTLE_RST  = 4'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXP_LO  = 3'd0,
		REG_EXP_HI  = 3'd1,
		REG_GAIN_LO = 3'd2,
		REG_GAIN_HI = 3'd3,
		REG_STEP    = 3'd4,
		REG_SETTLE  = 3'd5
	} cfg_reg_t;

	typedef enum logic [ADJ_W-1:0] {
		ADJ_NONE   = 2'd0,
		ADJ_BRIGHT = 2'd1,
		ADJ_DARK   = 2'd2
	} adj_t;

	typedef struct packed {
		logic [VAL_W-1:0] exp_lo;
		logic [VAL_W-1:0] exp_hi;
		logic [VAL_W-1:0] gain_lo;
		logic [VAL_W-1:0] gain_hi;
		logic [VAL_W-1:0] step;
	} limits_t;

	// one finished frame handed from front to back
	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [WSUM_W-1:0]  wsum;
		logic [VAL_W-1:0]   exposure;
		logic [VAL_W-1:0]   gain;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/hae_if.sv =====
// valid/ready channel interfaces for histogram bins and exposure results
// depends on hae_pkg
`default_nettype none

interface hae_bin_if import hae_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] bin_count;
	logic               last_bin;
	logic [VAL_W-1:0]   current_exposure;
	logic [VAL_W-1:0]   current_gain;

	modport source (output valid, bin_count, last_bin, current_exposure, current_gain,
		input ready);
	modport sink (input valid, bin_count, last_bin, current_exposure, current_gain,
		output ready);
endinterface

interface hae_res_if import hae_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] new_exposure;
	logic [VAL_W-1:0] new_gain;
	logic [ADJ_W-1:0] adjustment;

	modport source (output valid, new_exposure, new_gain, adjustment, input ready);
	modport sink (input valid, new_exposure, new_gain, adjustment, output ready);
endinterface

`default_nettype wire

// ===== rtl/hae_front.sv =====
// front end: accepts bins, accumulates total and region-weighted sums, handles settle
// skipping and pushes one record per unskipped frame; depends on hae_pkg, hae_if
`default_nettype none

module hae_front import hae_pkg::*; #(
	parameter int BINS = BINS_DEFAULT
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [SETTLE_W-1:0] settle_frames,
	hae_bin_if.sink            bin_ch,
	input  wire q_stat_t       q_stat,
	output logic               push,
	output frame_t             push_data
);

	localparam int RS   = BINS / REGIONS;
	localparam int PW   = $clog2(BINS + 1);
	localparam int CW   = $clog2(RS + 1);
	localparam int RGW  = 3;
	localparam int INCW = COUNT_W + RGW;

	logic [PW-1:0]       pos_q;
	logic [CW-1:0]       cnt_q;
	logic [RGW-1:0]      region_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [WSUM_W-1:0]   wsum_q;
	logic [SETTLE_W-1:0] skip_q;

	logic                accept;
	logic                in_range;
	logic [RGW-1:0]      weight;
	logic [INCW-1:0]     inc;
	logic [TOTAL_W:0]    total_add;
	logic [WSUM_W:0]     wsum_add;
	logic [TOTAL_W-1:0]  total_next;
	logic [WSUM_W-1:0]   wsum_next;

	assign bin_ch.ready = !q_stat.full;
	assign accept       = bin_ch.valid && bin_ch.ready;

	// weight of the current bin: region plus one, zero past the five regions
	assign in_range = pos_q < PW'(BINS);
	assign weight   = (in_range && region_q < RGW'(REGIONS)) ? region_q + RGW'(1) : '0;
	assign inc      = INCW'(bin_ch.bin_count) * INCW'(weight);

	// saturating accumulation
	assign total_add  = {1'b0, total_q} + (TOTAL_W+1)'(bin_ch.bin_count);
	assign total_next = total_add[TOTAL_W] ? '1 : total_add[TOTAL_W-1:0];
	assign wsum_add   = {1'b0, wsum_q} + (WSUM_W+1)'(inc);
	assign wsum_next  = wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];

	// frame record for the back end
	assign push               = accept && bin_ch.last_bin && skip_q == '0;
	assign push_data.total    = total_next;
	assign push_data.wsum     = wsum_next;
	assign push_data.exposure = bin_ch.current_exposure;
	assign push_data.gain     = bin_ch.current_gain;

	// position, region tracking and sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			cnt_q    <= '0;
			region_q <= '0;
			total_q  <= '0;
			wsum_q   <= '0;
			skip_q   <= '0;
		end else if (accept) begin
			if (bin_ch.last_bin) begin
				pos_q    <= '0;
				cnt_q    <= '0;
				region_q <= '0;
				total_q  <= '0;
				wsum_q   <= '0;
				if (skip_q != '0) begin
					skip_q <= skip_q - SETTLE_W'(1);
				end else begin
					skip_q <= settle_frames;
				end
			end else begin
				total_q <= total_next;
				wsum_q  <= wsum_next;
				if (in_range) begin
					pos_q <= pos_q + PW'(1);
					if (cnt_q == CW'(RS - 1)) begin
						cnt_q <= '0;
						if (region_q < RGW'(REGIONS)) begin
							region_q <= region_q + RGW'(1);
						end
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hae_fifo.sv =====
// short frame record queue between front and back end
// depends on hae_pkg
`default_nettype none

module hae_fifo import hae_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire frame_t push_data,
	input  wire logic   pop,
	output frame_t      pop_data,
	output q_stat_t     q_stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	frame_t        slot_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [NW-1:0] fill_q;

	assign q_stat.full  = fill_q == NW'(DEPTH);
	assign q_stat.empty = fill_q == '0;
	assign pop_data     = slot_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + NW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hae_back.sv =====
// back end: brightness test, exposure/gain step and clamping, result register
// depends on hae_pkg, hae_if
`default_nettype none

module hae_back import hae_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire limits_t limits,
	input  wire q_stat_t q_stat,
	input  wire frame_t  pop_data,
	output logic         pop,
	hae_res_if.source    res_ch
);

	localparam int NUMW = WSUM_W + 4;
	localparam int SW   = VAL_W + 2;

	// stage 1: scaled products
	logic                 v_s1;
	logic [NUMW-1:0]      num10_s1;
	logic [NUMW-1:0]      tlo_s1;
	logic [NUMW-1:0]      thi_s1;
	logic                 tzero_s1;
	logic [VAL_W-1:0]     exp_s1;
	logic [VAL_W-1:0]     gain_s1;

	// stage 2: band decision and candidate steps
	logic                 v_s2;
	adj_t                 adj_s2;
	logic signed [SW-1:0] exp_s2;
	logic signed [SW-1:0] gain_s2;
	logic signed [SW-1:0] exp_up_s2;
	logic signed [SW-1:0] exp_dn_s2;
	logic signed [SW-1:0] gain_up_s2;
	logic signed [SW-1:0] gain_dn_s2;
	logic                 exp_at_max_s2;
	logic                 gain_off_min_s2;

	// result register
	logic                 out_v_q;
	logic [VAL_W-1:0]     new_exp_q;
	logic [VAL_W-1:0]     new_gain_q;
	adj_t                 adj_q;

	logic                 en_out;
	logic                 en_s2;
	logic                 en_s1;
	adj_t                 adj_c;
	logic signed [SW-1:0] step_c;
	logic signed [SW-1:0] e_c;
	logic signed [SW-1:0] g_c;
	logic signed [SW-1:0] emin_c;
	logic signed [SW-1:0] emax_c;
	logic signed [SW-1:0] gmin_c;
	logic signed [SW-1:0] gmax_c;
	logic signed [SW-1:0] e_sel;
	logic signed [SW-1:0] g_sel;
	logic signed [SW-1:0] e_clamp;
	logic signed [SW-1:0] g_clamp;

	// stall chain
	assign en_out = !out_v_q || res_ch.ready;
	assign en_s2  = !v_s2 || en_out;
	assign en_s1  = !v_s1 || en_s2;
	assign pop    = en_s1 && !q_stat.empty;

	assign res_ch.valid        = out_v_q;
	assign res_ch.new_exposure = new_exp_q;
	assign res_ch.new_gain     = new_gain_q;
	assign res_ch.adjustment   = adj_q;

	// stage 1 products
	always_ff @(posedge clk) begin
		if (pop) begin
			num10_s1 <= NUMW'(pop_data.wsum) * NUMW'(MSV_SCALE);
			tlo_s1   <= NUMW'(pop_data.total) * NUMW'(MSV_LO_X10);
			thi_s1   <= NUMW'(pop_data.total) * NUMW'(MSV_HI_X10);
			tzero_s1 <= pop_data.total == '0;
			exp_s1   <= pop_data.exposure;
			gain_s1  <= pop_data.gain;
		end
	end

	// band decision
	always_comb begin
		adj_c = ADJ_NONE;
		if (!tzero_s1) begin
			if (num10_s1 < tlo_s1) begin
				adj_c = ADJ_BRIGHT;
			end else if (num10_s1 > thi_s1) begin
				adj_c = ADJ_DARK;
			end
		end
	end

	assign step_c = SW'(limits.step);
	assign e_c    = SW'(exp_s1);
	assign g_c    = SW'(gain_s1);

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			adj_s2          <= adj_c;
			exp_s2          <= e_c;
			gain_s2         <= g_c;
			exp_up_s2       <= e_c + step_c;
			exp_dn_s2       <= e_c - step_c;
			gain_up_s2      <= g_c + step_c;
			gain_dn_s2      <= g_c - step_c;
			exp_at_max_s2   <= exp_s1 == limits.exp_hi;
			gain_off_min_s2 <= gain_s1 != limits.gain_lo;
		end
	end

	// step selection
	assign emin_c = SW'(limits.exp_lo);
	assign emax_c = SW'(limits.exp_hi);
	assign gmin_c = SW'(limits.gain_lo);
	assign gmax_c = SW'(limits.gain_hi);

	always_comb begin
		e_sel = exp_s2;
		g_sel = gain_s2;
		case (adj_s2)
			ADJ_BRIGHT: begin
				e_sel = exp_up_s2;
				if (exp_up_s2 >= emax_c) begin
					g_sel = gain_up_s2;
				end
			end
			ADJ_DARK: begin
				if (exp_at_max_s2 && gain_off_min_s2) begin
					g_sel = gain_dn_s2;
				end else begin
					e_sel = exp_dn_s2;
				end
			end
			default: begin
				e_sel = exp_s2;
				g_sel = gain_s2;
			end
		endcase
	end

	// clamp: maximum first, then minimum
	assign e_clamp = (e_sel > emax_c) ? emax_c : ((e_sel < emin_c) ? emin_c : e_sel);
	assign g_clamp = (g_sel > gmax_c) ? gmax_c : ((g_sel < gmin_c) ? gmin_c : g_sel);

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			new_exp_q  <= e_clamp[VAL_W-1:0];
			new_gain_q <= g_clamp[VAL_W-1:0];
			adj_q      <= adj_s2;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= pop;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_out) begin
				out_v_q <= v_s2;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/histogram_auto_exposure.sv =====
// Histogram auto exposure: takes one luminance histogram bin per cycle on bin_ch
// while the queue has room and, at the last bin of each frame that is not being
// skipped, returns one exposure/gain update on res_ch. The end-of-frame record goes
// through a two-entry queue into a three-stage back end (products, band test, step and
// clamp). bin_ch stalls only while the queue holds two frames not yet taken by the
// back end. The user must write registers through cfg_we/cfg_index/cfg_data only while
// no frame is in flight; the block itself does not enforce this.
// depends on hae_pkg, hae_if, hae_front, hae_fifo, hae_back
`default_nettype none

module histogram_auto_exposure import hae_pkg::*; #(
	parameter int BINS = BINS_DEFAULT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [VAL_W-1:0]     cfg_data,
	hae_bin_if.sink                   bin_ch,
	hae_res_if.source                 res_ch
);

	limits_t             limits_q;
	logic [SETTLE_W-1:0] settle_q;
	q_stat_t             q_stat;
	logic                push;
	logic                pop;
	frame_t              push_data;
	frame_t              pop_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.exp_lo  <= EXP_LO_RST;
			limits_q.exp_hi  <= EXP_HI_RST;
			limits_q.gain_lo <= GAIN_LO_RST;
			limits_q.gain_hi <= GAIN_HI_RST;
			limits_q.step    <= STEP_RST;
			settle_q         <= SETTLE_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_EXP_LO:  limits_q.exp_lo  <= (cfg_data == '0) ? EXP_LO_RST : cfg_data;
				REG_EXP_HI:  limits_q.exp_hi  <= cfg_data;
				REG_GAIN_LO: limits_q.gain_lo <= (cfg_data == '0) ? GAIN_LO_RST : cfg_data;
				REG_GAIN_HI: limits_q.gain_hi <= cfg_data;
				REG_STEP:    limits_q.step    <= cfg_data;
				REG_SETTLE:  settle_q         <= cfg_data[SETTLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	hae_front #(
		.BINS (BINS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.settle_frames (settle_q),
		.bin_ch        (bin_ch),
		.q_stat        (q_stat),
		.push          (push),
		.push_data     (push_data)
	);

	hae_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	hae_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.limits   (limits_q),
		.q_stat   (q_stat),
		.pop_data (pop_data),
		.pop      (pop),
		.res_ch   (res_ch)
	);

endmodule

`default_nettype wire

// ===== test/histogram_auto_exposure_tb.sv =====
`timescale 1ns / 100ps

// self-checking testbench for histogram_auto_exposure: streams luminance histograms and
// register settings, predicts each exposure/gain update and checks it field by field
// depends on hae_pkg, hae_if and rtl/histogram_auto_exposure.sv

module histogram_auto_exposure_tb;
	import hae_pkg::*;

	localparam int BINS = BINS_DEFAULT;
	localparam int REGION_BINS = BINS / REGIONS;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int ITEMS_PER_PHASE = 185;
	localparam int MIN_UPDATES = 48;
	localparam int FIRST_THIRD = 550;
	localparam int SECOND_THIRD = 1100;
	localparam int PHASES = 8;
	localparam int NUM_REGS = 6;
	localparam longint unsigned TOTAL_CAP = (64'd1 << TOTAL_W) - 64'd1;
	localparam longint unsigned WSUM_CAP = (64'd1 << WSUM_W) - 64'd1;

	typedef struct {
		logic [COUNT_W-1:0] count;
		logic               last;
		logic [VAL_W-1:0]   exposure;
		logic [VAL_W-1:0]   gain;
	} bin_item_t;

	typedef struct {
		logic [VAL_W-1:0] exposure;
		logic [VAL_W-1:0] gain;
		logic [ADJ_W-1:0] adj;
	} update_t;

	// histogram shapes used to steer the mean sample value
	typedef enum {
		SHAPE_DARK, SHAPE_BRIGHT, SHAPE_MID, SHAPE_FLAT, SHAPE_SPARSE, SHAPE_ZERO,
		SHAPE_EDGE, SHAPE_FULL
	} shape_t;

	// exposure predictor and queue of pending updates
	class exposure_scoreboard;
		logic [VAL_W-1:0]    exp_lo, exp_hi, gain_lo, gain_hi, step;
		logic [SETTLE_W-1:0] settle;
		int unsigned         position;
		longint unsigned     total, wsum;
		int unsigned         skip;
		update_t             expected_q[$];
		int                  errors, bins_seen, frames_seen, frames_skipped, updates_checked;
		int                  adj_count[3];

		function new();
			exp_lo = EXP_LO_RST;
			exp_hi = EXP_HI_RST;
			gain_lo = GAIN_LO_RST;
			gain_hi = GAIN_HI_RST;
			step = STEP_RST;
			settle = SETTLE_RST;
			skip = 0;
			errors = 0;
			bins_seen = 0;
			frames_seen = 0;
			frames_skipped = 0;
			updates_checked = 0;
			adj_count = '{0, 0, 0};
			clear_frame();
		endfunction

		function void clear_frame();
			position = 0;
			total = 0;
			wsum = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [VAL_W-1:0] data);
			case (idx)
				REG_EXP_LO:  exp_lo = (data == '0) ? EXP_LO_RST : data;
				REG_EXP_HI:  exp_hi = data;
				REG_GAIN_LO: gain_lo = (data == '0) ? GAIN_LO_RST : data;
				REG_GAIN_HI: gain_hi = data;
				REG_STEP:    step = data;
				REG_SETTLE:  settle = data[SETTLE_W-1:0];
				default: ;
			endcase
		endfunction

		// upper limit wins over lower limit
		function int clip(int v, int lo, int hi);
			if (v > hi)
				return hi;
			if (v < lo)
				return lo;
			return v;
		endfunction

		function void note_bin(bin_item_t b);
			int              e, g, s, emax, gmin;
			int unsigned     region;
			longint unsigned num10;
			update_t         u;
			bins_seen++;
			// accumulate, tail bins only count toward the total
			total += 64'(b.count);
			if (total > TOTAL_CAP)
				total = TOTAL_CAP;
			if (position < BINS) begin
				region = position / REGION_BINS;
				if (region < REGIONS) begin
					wsum += 64'(b.count) * 64'(region + 1);
					if (wsum > WSUM_CAP)
						wsum = WSUM_CAP;
				end
				position++;
			end
			if (!b.last)
				return;
			frames_seen++;
			// settling frame: no update
			if (skip > 0) begin
				skip--;
				frames_skipped++;
				clear_frame();
				return;
			end
			e = b.exposure;
			g = b.gain;
			s = step;
			emax = exp_hi;
			gmin = gain_lo;
			u.adj = ADJ_NONE;
			// band test on 10*weighted against 23 and 27 times the total
			if (total != 0) begin
				num10 = wsum * MSV_SCALE;
				if (num10 < total * MSV_LO_X10) begin
					u.adj = ADJ_BRIGHT;
					e += s;
					if (e >= emax)
						g += s;
				end else if (num10 > total * MSV_HI_X10) begin
					u.adj = ADJ_DARK;
					if (e == emax && g != gmin)
						g -= s;
					else
						e -= s;
				end
			end
			u.exposure = VAL_W'(clip(e, exp_lo, exp_hi));
			u.gain = VAL_W'(clip(g, gain_lo, gain_hi));
			expected_q.push_back(u);
			adj_count[u.adj]++;
			skip = settle;
			clear_frame();
		endfunction

		function void check_update(update_t r);
			update_t x;
			if (expected_q.size() == 0) begin
				$error("unexpected update: new_exposure %0d new_gain %0d adjustment %0d",
					r.exposure, r.gain, r.adj);
				errors++;
				return;
			end
			x = expected_q.pop_front();
			updates_checked++;
			if (r.exposure !== x.exposure) begin
				$error("new_exposure: expected %0d, got %0d", x.exposure, r.exposure);
				errors++;
			end
			if (r.gain !== x.gain) begin
				$error("new_gain: expected %0d, got %0d", x.gain, r.gain);
				errors++;
			end
			if (r.adj !== x.adj) begin
				$error("adjustment: expected %0d, got %0d", x.adj, r.adj);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VAL_W-1:0]     cfg_data;

	int src_idle = 19;
	int snk_idle = 61;
	int hold_len = 0;
	int bins_sent = 0;
	int long_frames = 0;
	int cycles = 0;

	exposure_scoreboard sb;

	hae_bin_if bin_ch();
	hae_res_if res_ch();

	histogram_auto_exposure #(.BINS(BINS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.bin_ch(bin_ch),
		.res_ch(res_ch)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT_CYCLES) begin
			$display("run stopped after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// observe accepted items on both channels
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (bin_ch.valid && bin_ch.ready)
				sb.note_bin(bin_item_t'{bin_ch.bin_count, bin_ch.last_bin,
					bin_ch.current_exposure, bin_ch.current_gain});
			if (res_ch.valid && res_ch.ready)
				sb.check_update(update_t'{res_ch.new_exposure, res_ch.new_gain,
					res_ch.adjustment});
		end
	end

	// result receiver: random stalls, plus long hold-offs on request
	initial begin
		int hold_left;
		hold_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				hold_left = hold_len;
				hold_len = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
			end
		end
	end

	// bin count of random magnitude, now and then full scale
	function automatic logic [COUNT_W-1:0] rnd_count();
		int unsigned bits;
		logic [31:0] mask;
		if ($urandom_range(0, 9) == 0)
			return '1;
		bits = $urandom_range(0, COUNT_W);
		mask = (32'd1 << bits) - 32'd1;
		return COUNT_W'($urandom & mask);
	endfunction

	// sensor value near the interesting points of a limit pair
	function automatic logic [VAL_W-1:0] pick_level(int lo, int hi, int stp);
		int v;
		case ($urandom_range(0, 7))
			0: v = lo;
			1: v = hi;
			2: v = 0;
			3: v = 65535;
			4: v = hi - stp;
			5: v = lo + stp;
			6: v = hi + 1;
			default: v = $urandom_range(0, 65535);
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return VAL_W'(v);
	endfunction

	function automatic void update_idle();
		if (bins_sent < FIRST_THIRD) begin
			src_idle = 19;
			snk_idle = 61;
		end else if (bins_sent < SECOND_THIRD) begin
			src_idle = 61;
			snk_idle = 19;
		end else begin
			src_idle = 0;
			snk_idle = 0;
		end
	endfunction

	// offer one item, return at the falling edge after it is taken
	task automatic send_bin(input bin_item_t it);
		while ($urandom_range(0, 99) < src_idle) begin
			bin_ch.valid <= 1'b0;
			@(negedge clk);
		end
		bin_ch.valid <= 1'b1;
		bin_ch.bin_count <= it.count;
		bin_ch.last_bin <= it.last;
		bin_ch.current_exposure <= it.exposure;
		bin_ch.current_gain <= it.gain;
		@(posedge clk);
		while (!bin_ch.ready)
			@(posedge clk);
		@(negedge clk);
		bins_sent++;
	endtask

	task automatic send_frame(input int len, input shape_t shape,
			input logic [VAL_W-1:0] exposure, input logic [VAL_W-1:0] gain);
		bin_item_t   it;
		int          pos, delta;
		int unsigned base, k, wa, wb;
		base = $urandom_range(1, 1 << 20);
		k = $urandom_range(1, 900000);
		delta = int'($urandom_range(0, 2)) - 1;
		// weights 1 and 3 in these ratios put the value right on the lower or upper edge
		if ($urandom_range(0, 1)) begin
			wa = 7;
			wb = 13;
		end else begin
			wa = 3;
			wb = 17;
		end
		if (shape == SHAPE_EDGE && len <= 2 * REGION_BINS)
			len = 2 * REGION_BINS + 1;
		for (pos = 0; pos < len; pos++) begin
			case (shape)
				SHAPE_DARK:
					it.count = (pos < 2 * REGION_BINS) ? rnd_count() :
						COUNT_W'($urandom_range(0, 255));
				SHAPE_BRIGHT:
					it.count = (pos >= 3 * REGION_BINS) ? rnd_count() :
						COUNT_W'($urandom_range(0, 255));
				SHAPE_MID:
					it.count = (pos >= 2 * REGION_BINS && pos < 4 * REGION_BINS) ?
						COUNT_W'(base + $urandom_range(0, base / 4)) : '0;
				SHAPE_FLAT:
					it.count = rnd_count();
				SHAPE_SPARSE:
					it.count = ($urandom_range(0, 5) == 0) ? rnd_count() : '0;
				SHAPE_ZERO:
					it.count = '0;
				SHAPE_EDGE: begin
					if (pos == 0)
						it.count = COUNT_W'(wa * k);
					else if (pos == 2 * REGION_BINS)
						it.count = COUNT_W'(int'(wb * k) + delta);
					else
						it.count = '0;
				end
				default:
					it.count = '1;
			endcase
			it.last = (pos == len - 1);
			it.exposure = it.last ? exposure : VAL_W'($urandom);
			it.gain = it.last ? gain : VAL_W'($urandom);
			send_bin(it);
		end
	endtask

	// stop offering, wait for every pending update, then let the back end settle
	task automatic wait_idle();
		bin_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_regs(input logic [VAL_W-1:0] vals [NUM_REGS]);
		cfg_reg_t idx [NUM_REGS] = '{REG_EXP_LO, REG_EXP_HI, REG_GAIN_LO, REG_GAIN_HI,
			REG_STEP, REG_SETTLE};
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			sb.write_reg(idx[i], vals[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// stimulus
	initial begin
		logic [VAL_W-1:0] phase_cfg [PHASES][NUM_REGS];
		logic [VAL_W-1:0] cfg_row [NUM_REGS];
		int               phase, quota, len, pick;
		shape_t           shape;
		bit               short_only;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_EXP_LO;
		cfg_data = '0;
		bin_ch.valid = 1'b0;
		bin_ch.bin_count = '0;
		bin_ch.last_bin = 1'b0;
		bin_ch.current_exposure = '0;
		bin_ch.current_gain = '0;

		// limit sets: zero writes, tight band, full step, no step, crossed limits,
		// all at top with long settling, then two random ones
		phase_cfg[0] = '{16'd0, 16'd65535, 16'd0, 16'd65535, 16'd30, 16'h0000};
		phase_cfg[1] = '{16'd100, 16'd400, 16'd100, 16'd200, 16'd30, 16'h1231};
		phase_cfg[2] = '{16'd1, 16'd65535, 16'd1, 16'd65535, 16'd65535, 16'h0000};
		phase_cfg[3] = '{16'd500, 16'd500, 16'd300, 16'd300, 16'd0, 16'hA5A2};
		phase_cfg[4] = '{16'd5000, 16'd100, 16'd2000, 16'd50, 16'd100, 16'h0000};
		phase_cfg[5] = '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd1, 16'hFFFF};
		phase_cfg[6] = '{16'd200, 16'd3000, 16'd100, 16'd1000,
			VAL_W'($urandom_range(1, 500)), 16'h0003};
		phase_cfg[7] = '{VAL_W'($urandom_range(0, 3000)), VAL_W'($urandom_range(2000, 65535)),
			VAL_W'($urandom_range(0, 3000)), VAL_W'($urandom_range(2000, 65535)),
			VAL_W'($urandom_range(0, 2000)),
			VAL_W'(($urandom & 32'hFFF0) | $urandom_range(0, 3))};

		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames on reset limits, two frames skipped after each update
		send_frame(1, SHAPE_ZERO, 16'd0, 16'd0);
		send_frame(1, SHAPE_FULL, 16'hFFFF, 16'hFFFF);
		send_frame(2, SHAPE_FULL, 16'd0, 16'hFFFF);
		send_frame(1, SHAPE_FULL, 16'hFFFF, 16'hFFFF);
		send_frame(1, SHAPE_FLAT, 16'd1234, 16'd4321);
		send_frame(1, SHAPE_SPARSE, 16'd0, 16'd0);
		// exposure reaches its maximum, so gain steps as well and clamps
		send_frame(3, SHAPE_DARK, 16'd65505, 16'd65530);
		send_frame(1, SHAPE_ZERO, 16'hFFFF, 16'd0);
		send_frame(1, SHAPE_FULL, 16'd0, 16'hFFFF);
		// gain below its minimum
		send_frame(4, SHAPE_DARK, 16'd1, 16'd50);
		wait_idle();

		// random frames over each limit set
		for (phase = 0; phase < PHASES; phase++) begin
			cfg_row = phase_cfg[phase];
			write_regs(cfg_row);
			short_only = (phase_cfg[phase][NUM_REGS-1][SETTLE_W-1:0] > 4);

			// receiver holds off while tiny frames pile up behind it
			if (phase == 2) begin
				@(posedge clk);
				hold_len = 400;
				@(negedge clk);
				src_idle = 0;
				repeat (20)
					send_frame($urandom_range(1, 2), SHAPE_FLAT,
						pick_level(sb.exp_lo, sb.exp_hi, sb.step),
						pick_level(sb.gain_lo, sb.gain_hi, sb.step));
				wait_idle();
			end

			quota = bins_sent + ITEMS_PER_PHASE;
			while (bins_sent < quota ||
					(phase == PHASES - 1 && sb.updates_checked < MIN_UPDATES)) begin
				update_idle();
				pick = $urandom_range(0, 99);
				shape = shape_t'($urandom_range(0, 6));
				if (short_only) begin
					len = $urandom_range(1, 6);
				end else if (long_frames < (phase + 2) / 3) begin
					// enough full-scale bins to saturate the total
					len = $urandom_range(260, 300);
					shape = SHAPE_FULL;
					long_frames++;
				end else if (pick < 40) begin
					len = BINS;
				end else if (pick < 52) begin
					len = $urandom_range(BINS - 3, BINS + 8);
				end else begin
					len = $urandom_range(1, 30);
				end
				send_frame(len, shape, pick_level(sb.exp_lo, sb.exp_hi, sb.step),
					pick_level(sb.gain_lo, sb.gain_hi, sb.step));
			end
			wait_idle();
		end

		if (sb.expected_q.size() != 0) begin
			$error("%0d updates never arrived", sb.expected_q.size());
			sb.errors++;
		end
		$display("checked %0d updates from %0d bins in %0d frames, %0d frames skipped",
			sb.updates_checked, sb.bins_seen, sb.frames_seen, sb.frames_skipped);
		$display("adjustments: %0d in band, %0d brighten, %0d darken over %0d limit sets",
			sb.adj_count[ADJ_NONE], sb.adj_count[ADJ_BRIGHT], sb.adj_count[ADJ_DARK], PHASES);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
